[design/scl_pkg.sv]
// Package for the shell command lexer: token kinds, lexing modes, character codes,
// offset type and the character-class helper functions.
// It has no dependencies and is used by shell_command_lexer.
package scl_pkg;

  localparam int OffsetBits = 16;
  localparam int OutBits    = 16;
  localparam int FifoDepth  = 4;
  localparam int PtrBits    = $clog2(FifoDepth);
  localparam int CntBits    = $clog2(FifoDepth + 1);

  typedef logic [OffsetBits-1:0] offset_t;

  typedef enum logic [3:0] {
    KSpace   = 4'd0,
    KOpen    = 4'd1,
    KClose   = 4'd2,
    KSemi    = 4'd3,
    KAndAnd  = 4'd4,
    KOrOr    = 4'd5,
    KNewline = 4'd6,
    KNumber  = 4'd7,
    KWord    = 4'd8,
    KString  = 4'd9,
    KBang    = 4'd10,
    KEof     = 4'd11,
    KError   = 4'd12
  } kind_e;

  typedef enum logic [8:0] {
    MIdle   = 9'b000000001,
    MSpace  = 9'b000000010,
    MNumber = 9'b000000100,
    MWord   = 9'b000001000,
    MAmp    = 9'b000010000,
    MBar    = 9'b000100000,
    MDq     = 9'b001000000,
    MSq     = 9'b010000000,
    MError  = 9'b100000000
  } mode_e;

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChOpen    = 8'h28;
  localparam logic [7:0] ChClose   = 8'h29;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChBang    = 8'h21;
  localparam logic [7:0] ChDquote  = 8'h22;
  localparam logic [7:0] ChSquote  = 8'h27;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChBar     = 8'h7C;
  localparam logic [7:0] ChUnder   = 8'h5F;
  localparam logic [7:0] ChHyphen  = 8'h2D;
  localparam logic [7:0] ChSlash   = 8'h2F;

  // One queued result.
  typedef struct packed {
    kind_e              kind;
    logic [OutBits-1:0] start_off;
    logic [OutBits-1:0] end_off;
    logic               last;
  } result_t;

  // What a character does when it arrives with no token pending.
  typedef struct packed {
    mode_e mode;
    logic  set_begin;
    logic  emit;
    kind_e kind;
  } idle_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == ChUnder) || (c == ChHyphen) || (c == ChSlash);
  endfunction

  function automatic offset_t sat_inc(offset_t v);
    return (v == {OffsetBits{1'b1}}) ? v : v + offset_t'(1);
  endfunction

  function automatic logic [OutBits-1:0] to_out(offset_t v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'h0FFFF) ? {OutBits{1'b1}} : w[OutBits-1:0];
  endfunction

  function automatic idle_t from_idle(logic [7:0] c);
    idle_t r;
    r.mode      = MIdle;
    r.set_begin = 1'b0;
    r.emit      = 1'b0;
    r.kind      = KError;
    if (c == ChSpace) begin
      r.mode = MSpace;
      r.set_begin = 1'b1;
    end else if (c == ChOpen) begin
      r.emit = 1'b1;
      r.kind = KOpen;
    end else if (c == ChClose) begin
      r.emit = 1'b1;
      r.kind = KClose;
    end else if (c == ChSemi) begin
      r.emit = 1'b1;
      r.kind = KSemi;
    end else if (c == ChNewline) begin
      r.emit = 1'b1;
      r.kind = KNewline;
    end else if (c == ChBang) begin
      r.emit = 1'b1;
      r.kind = KBang;
    end else if (is_digit(c)) begin
      r.mode = MNumber;
      r.set_begin = 1'b1;
    end else if (is_word(c)) begin
      r.mode = MWord;
      r.set_begin = 1'b1;
    end else if (c == ChDquote) begin
      r.mode = MDq;
      r.set_begin = 1'b1;
    end else if (c == ChSquote) begin
      r.mode = MSq;
      r.set_begin = 1'b1;
    end else if (c == ChAmp) begin
      r.mode = MAmp;
      r.set_begin = 1'b1;
    end else if (c == ChBar) begin
      r.mode = MBar;
      r.set_begin = 1'b1;
    end else begin
      r.mode = MError;
      r.emit = 1'b1;
      r.kind = KError;
    end
    return r;
  endfunction

endpackage

[design/shell_command_lexer.sv]
// Shell command lexer: one character or end-of-input mark per input transaction,
// up to two tokens out per transaction. Depends on scl_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries op_i (0 character, 1 end of
//   input) and char_code_i. Output channel (out_valid_o/out_ready_i) carries
//   one token per transaction: kind, start and end offsets, and last_in_run_o
//   on the final token caused by an input transaction.
//   The configuration channel (cfg_valid_i/cfg_ready_o) writes keep_separators;
//   it is always ready and should be written only while the lexer is idle.
// Timing:
//   The lexer state is updated in the cycle an input is accepted and its tokens
//   enter a four-entry result queue; the first token is visible in the cycle
//   after acceptance. One input is accepted per cycle while the queue has room for
//   two tokens; the queue drains one token per cycle while out_ready_i is high,
//   so inputs that yield two tokens are paced by the output port.
// Reset and stall:
//   Reset empties the queue, clears the offsets and keep_separators, and puts
//   the lexer in the idle mode. When the receiver stalls, tokens wait in the
//   queue and in_ready_o drops once fewer than two entries are free.
module shell_command_lexer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      op_i,
  input  logic [7:0]                char_code_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_keep_separators_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [3:0]                token_kind_o,
  output logic [scl_pkg::OutBits-1:0] start_offset_o,
  output logic [scl_pkg::OutBits-1:0] end_offset_o,
  output logic                      last_in_run_o
);

  scl_pkg::mode_e   mode_q, mode_d;
  scl_pkg::offset_t begin_q, begin_d;
  scl_pkg::offset_t pos_q, pos_d;
  logic             keep_q;

  scl_pkg::result_t fifo_q [scl_pkg::FifoDepth];
  logic [scl_pkg::PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [scl_pkg::CntBits-1:0] count_q;

  logic             in_acc, out_acc;
  scl_pkg::idle_t   fi;
  logic             use_fi;
  logic             a_vld, b_vld;
  scl_pkg::kind_e   a_kind, b_kind;
  scl_pkg::offset_t a_start, a_end, b_start, b_end;
  scl_pkg::offset_t nx;
  scl_pkg::result_t r0, r1;
  logic [1:0]       push_cnt;

  assign in_ready_o  = (count_q <= scl_pkg::CntBits'(scl_pkg::FifoDepth - 2));
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_acc     = out_valid_o & out_ready_i;

  always_comb begin
    fi      = scl_pkg::from_idle(char_code_i);
    nx      = scl_pkg::sat_inc(pos_q);
    mode_d  = mode_q;
    begin_d = begin_q;
    pos_d   = pos_q;
    use_fi  = 1'b0;
    a_vld   = 1'b0;
    a_kind  = scl_pkg::KSpace;
    a_start = begin_q;
    a_end   = pos_q;
    b_vld   = 1'b0;
    b_kind  = scl_pkg::KEof;
    b_start = pos_q;
    b_end   = nx;
    if (in_acc) begin
      if (op_i) begin
        // Flush the pending token, then eof; offsets restart from zero.
        unique case (mode_q) inside
          scl_pkg::MSpace: begin
            a_vld  = keep_q;
            a_kind = scl_pkg::KSpace;
          end
          scl_pkg::MNumber: begin
            a_vld  = 1'b1;
            a_kind = scl_pkg::KNumber;
          end
          scl_pkg::MWord: begin
            a_vld  = 1'b1;
            a_kind = scl_pkg::KWord;
          end
          scl_pkg::MAmp, scl_pkg::MBar, scl_pkg::MDq, scl_pkg::MSq: begin
            a_vld  = 1'b1;
            a_kind = scl_pkg::KError;
            a_end  = scl_pkg::sat_inc(begin_q);
          end
          default: begin
            a_vld = 1'b0;
          end
        endcase
        b_vld   = 1'b1;
        b_kind  = scl_pkg::KEof;
        b_end   = pos_q;
        mode_d  = scl_pkg::MIdle;
        begin_d = '0;
        pos_d   = '0;
      end else begin
        pos_d = nx;
        unique case (mode_q) inside
          scl_pkg::MSpace: begin
            if (char_code_i != scl_pkg::ChSpace) begin
              a_vld  = keep_q;
              a_kind = scl_pkg::KSpace;
              use_fi = 1'b1;
            end
          end
          scl_pkg::MNumber: begin
            if (!scl_pkg::is_digit(char_code_i)) begin
              a_vld  = 1'b1;
              a_kind = scl_pkg::KNumber;
              if (scl_pkg::is_word(char_code_i)) begin
                mode_d  = scl_pkg::MWord;
                begin_d = pos_q;
              end else begin
                use_fi = 1'b1;
              end
            end
          end
          scl_pkg::MWord: begin
            if (!scl_pkg::is_word(char_code_i)) begin
              a_vld  = 1'b1;
              a_kind = scl_pkg::KWord;
              use_fi = 1'b1;
            end
          end
          scl_pkg::MAmp, scl_pkg::MBar: begin
            a_vld = 1'b1;
            if (char_code_i == ((mode_q == scl_pkg::MAmp) ? scl_pkg::ChAmp
                                                         : scl_pkg::ChBar)) begin
              a_kind = (mode_q == scl_pkg::MAmp) ? scl_pkg::KAndAnd : scl_pkg::KOrOr;
              a_end  = nx;
              mode_d = scl_pkg::MIdle;
            end else begin
              a_kind = scl_pkg::KError;
              a_end  = scl_pkg::sat_inc(begin_q);
              mode_d = scl_pkg::MError;
            end
          end
          scl_pkg::MDq, scl_pkg::MSq: begin
            if (char_code_i == ((mode_q == scl_pkg::MDq) ? scl_pkg::ChDquote
                                                        : scl_pkg::ChSquote)) begin
              a_vld  = 1'b1;
              a_kind = scl_pkg::KString;
              a_end  = nx;
              mode_d = scl_pkg::MIdle;
            end
          end
          scl_pkg::MError: begin
            mode_d = scl_pkg::MError;
          end
          default: begin
            use_fi = 1'b1;
          end
        endcase
        if (use_fi) begin
          mode_d = fi.mode;
          if (fi.set_begin) begin
            begin_d = pos_q;
          end
          b_vld  = fi.emit;
          b_kind = fi.kind;
        end
      end
    end
  end

  // Compact the two candidate tokens so that the first valid one goes first.
  always_comb begin
    r1.kind      = b_kind;
    r1.start_off = scl_pkg::to_out(b_start);
    r1.end_off   = scl_pkg::to_out(b_end);
    r1.last      = 1'b1;
    if (a_vld) begin
      r0.kind      = a_kind;
      r0.start_off = scl_pkg::to_out(a_start);
      r0.end_off   = scl_pkg::to_out(a_end);
      r0.last      = !b_vld;
    end else begin
      r0 = r1;
    end
    push_cnt = {1'b0, a_vld} + {1'b0, b_vld};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= scl_pkg::MIdle;
      begin_q  <= '0;
      pos_q    <= '0;
      keep_q   <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      mode_q   <= mode_d;
      begin_q  <= begin_d;
      pos_q    <= pos_d;
      if (cfg_valid_i && cfg_ready_o) begin
        keep_q <= cfg_keep_separators_i;
      end
      wr_ptr_q <= wr_ptr_q + scl_pkg::PtrBits'(push_cnt);
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + scl_pkg::PtrBits'(1);
      end
      count_q  <= count_q + scl_pkg::CntBits'(push_cnt)
                  - scl_pkg::CntBits'(out_acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt != 2'd0) begin
      fifo_q[wr_ptr_q] <= r0;
    end
    if (push_cnt == 2'd2) begin
      fifo_q[wr_ptr_q + scl_pkg::PtrBits'(1)] <= r1;
    end
  end

  assign token_kind_o   = fifo_q[rd_ptr_q].kind;
  assign start_offset_o = fifo_q[rd_ptr_q].start_off;
  assign end_offset_o   = fifo_q[rd_ptr_q].end_off;
  assign last_in_run_o  = fifo_q[rd_ptr_q].last;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= scl_pkg::CntBits'(scl_pkg::FifoDepth))
    else $error("result queue overflow");

  a_eof_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op_i) |-> (push_cnt != 2'd0))
    else $error("end of input produced no eof token");

  a_eof_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op_i) |=> (pos_q == '0 && mode_q == scl_pkg::MIdle))
    else $error("end of input did not restart the offsets");

  a_error_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !op_i && mode_q == scl_pkg::MError) |=>
      (mode_q == scl_pkg::MError && count_q <= $past(count_q)))
    else $error("error mode left or emitted before end of input");
`endif

endmodule
